>>> hw/rtl/fplc_pkg.sv
`default_nettype none

package fplc_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 5;
   localparam int POS_W    = 5;

   // Sizing and number format
   localparam int MAX_FIRST_LENGTH  = 16;
   localparam int MAX_SECOND_LENGTH = 16;
   localparam int PRODUCT_FRAC_BITS = 14;
   localparam int SUM_FRAC_BITS     = 13;

   // Register reset values
   localparam logic [CFG_W-1:0] FIRST_LENGTH_RESET  = CFG_W'(16);
   localparam logic [CFG_W-1:0] SECOND_LENGTH_RESET = CFG_W'(10);

   // Register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_LENGTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_LENGTH = 1'b1;

   // Derived widths
   localparam int MAX_LEN       = (MAX_FIRST_LENGTH > MAX_SECOND_LENGTH) ?
                                  MAX_FIRST_LENGTH : MAX_SECOND_LENGTH;
   localparam int LEN_W         = $clog2(MAX_LEN + 1);
   localparam int IDX1_W        = (MAX_FIRST_LENGTH > 1) ? $clog2(MAX_FIRST_LENGTH) : 1;
   localparam int IDX2_W        = (MAX_SECOND_LENGTH > 1) ? $clog2(MAX_SECOND_LENGTH) : 1;
   localparam int FIRST_ADDR_W  = IDX1_W + 1;
   localparam int SECOND_ADDR_W = IDX2_W + 1;
   localparam int N_W           = $clog2(MAX_FIRST_LENGTH + MAX_SECOND_LENGTH);
   localparam int SUM_W         = N_W + 1;
   localparam int PROD_W        = 2 * SAMPLE_W;

   // Product to sum format: shift down (truncate toward zero) or up
   localparam int FRAC_DIFF = PRODUCT_FRAC_BITS - SUM_FRAC_BITS;
   localparam int SHIFT_DN  = (FRAC_DIFF >= 0) ? FRAC_DIFF : 0;
   localparam int SHIFT_UP  = (FRAC_DIFF < 0) ? -FRAC_DIFF : 0;
   localparam logic signed [SAMPLE_W-1:0] TERM_BIAS = SAMPLE_W'((1 << SHIFT_DN) - 1);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] first_len;
      logic [LEN_W-1:0] second_len;
   } job_type;

   typedef struct packed {
      logic                      first_en;
      logic                      second_en;
      logic [FIRST_ADDR_W-1:0]   first_addr;
      logic [SECOND_ADDR_W-1:0]  second_addr;
      logic [SAMPLE_W-1:0]       data;
   } wr_type;

   typedef struct packed {
      logic active;
      logic done;
      logic bank;
   } back_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_START,
      BK_ISSUE,
      BK_DRAIN
   } back_state_type;

   // Length register to working length: zero acts as one, clamp at the store size
   function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v, input int lim);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (int'(v) > lim) begin
         r = LEN_W'(lim);
      end else begin
         r = LEN_W'(v);
      end
      return r;
   endfunction

   // One product moved to the sum format, wrapped to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] term_fn(input logic signed [PROD_W-1:0] prod);
      logic signed [SAMPLE_W-1:0] z;
      logic signed [SAMPLE_W-1:0] bias;
      logic signed [SAMPLE_W-1:0] r;
      z    = prod[PRODUCT_FRAC_BITS +: SAMPLE_W];
      bias = z[SAMPLE_W-1] ? TERM_BIAS : '0;
      if (SHIFT_UP == 0) begin
         r = (z + bias) >>> SHIFT_DN;
      end else begin
         r = z <<< SHIFT_UP;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fplc_ram.sv
`default_nettype none

module fplc_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fplc_queue.sv
`default_nettype none

module fplc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire fplc_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  head_valid,
   output fplc_pkg::job_type     head_job,
   output logic                  full
);

   import fplc_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> hw/rtl/fplc_front.sv
`default_nettype none

module fplc_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [fplc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [fplc_pkg::CFG_W-1:0]             csr_data,
   // samples
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_mode,
   input  wire logic [fplc_pkg::SAMPLE_W-1:0]          req_sample,
   // store writes and job hand-off
   output fplc_pkg::wr_type                            wr,
   output logic                                        job_push,
   output fplc_pkg::job_type                           job,
   input  wire logic                                   queue_full,
   input  wire fplc_pkg::back_stat_type                stat
);

   import fplc_pkg::*;

   logic [CFG_W-1:0] first_length_ff, first_length_in;
   logic [CFG_W-1:0] second_length_ff, second_length_in;
   logic [LEN_W-1:0] first_count_ff, first_count_in;
   logic [LEN_W-1:0] second_count_ff, second_count_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic [LEN_W-1:0] first_len, second_len;
   logic [LEN_W-1:0] first_next, second_next;
   logic             accept, wr_first, wr_second, complete;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      first_length_in  = first_length_ff;
      second_length_in = second_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_LENGTH:  first_length_in  = csr_data;
            CSR_SECOND_LENGTH: second_length_in = csr_data;
            default: ;
         endcase
      end
   end

   assign first_len  = eff_len(first_length_ff, MAX_FIRST_LENGTH);
   assign second_len = eff_len(second_length_ff, MAX_SECOND_LENGTH);

   // Take a beat only when the fill bank is free and the queue has room
   assign req_ready = !busy_ff[bank_ff] && !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the beat: store it or drop it when its sequence is full
   assign wr_first  = accept && !req_mode && (first_count_ff < first_len) &&
                      (first_count_ff < LEN_W'(MAX_FIRST_LENGTH));
   assign wr_second = accept && req_mode && (second_count_ff < second_len) &&
                      (second_count_ff < LEN_W'(MAX_SECOND_LENGTH));

   assign first_next  = first_count_ff + LEN_W'(wr_first);
   assign second_next = second_count_ff + LEN_W'(wr_second);
   assign complete    = accept && (first_next >= first_len) && (second_next >= second_len);

   assign wr.first_en    = wr_first;
   assign wr.second_en   = wr_second;
   assign wr.first_addr  = {bank_ff, first_count_ff[IDX1_W-1:0]};
   assign wr.second_addr = {bank_ff, second_count_ff[IDX2_W-1:0]};
   assign wr.data        = req_sample;

   assign job_push       = complete;
   assign job.bank       = bank_ff;
   assign job.first_len  = first_len;
   assign job.second_len = second_len;

   // Counts, fill bank and bank ownership
   always_comb begin
      first_count_in  = complete ? '0 : first_next;
      second_count_in = complete ? '0 : second_next;
      bank_in         = complete ? !bank_ff : bank_ff;
      busy_in         = busy_ff;
      if (complete) begin
         busy_in[bank_ff] = 1'b1;
      end
      if (stat.done) begin
         busy_in[stat.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_length_ff  <= FIRST_LENGTH_RESET;
         second_length_ff <= SECOND_LENGTH_RESET;
         first_count_ff   <= '0;
         second_count_ff  <= '0;
         bank_ff          <= 1'b0;
         busy_ff          <= '0;
      end else begin
         first_length_ff  <= first_length_in;
         second_length_ff <= second_length_in;
         first_count_ff   <= first_count_in;
         second_count_ff  <= second_count_in;
         bank_ff          <= bank_in;
         busy_ff          <= busy_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fplc_back.sv
`default_nettype none

module fplc_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // job queue
   input  wire logic                                job_valid,
   input  wire fplc_pkg::job_type                   job,
   output logic                                     job_pop,
   // store reads
   output logic                                     rd_en,
   output logic [fplc_pkg::FIRST_ADDR_W-1:0]        rd_first_addr,
   output logic [fplc_pkg::SECOND_ADDR_W-1:0]       rd_second_addr,
   input  wire logic [fplc_pkg::SAMPLE_W-1:0]       rd_first_data,
   input  wire logic [fplc_pkg::SAMPLE_W-1:0]       rd_second_data,
   // status
   output fplc_pkg::back_stat_type                  stat,
   // results
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [fplc_pkg::SAMPLE_W-1:0]     rsp_result,
   output logic [fplc_pkg::POS_W-1:0]               rsp_position,
   output logic                                     rsp_final_res
);

   import fplc_pkg::*;

   back_state_type              state_ff, state_in;
   logic                        bank_ff, bank_in;
   logic [LEN_W-1:0]            first_len_ff, first_len_in;
   logic [LEN_W-1:0]            second_len_ff, second_len_in;
   logic [N_W-1:0]              last_n_ff, last_n_in;
   logic [N_W-1:0]              n_ff, n_in;
   logic [LEN_W-1:0]            j_ff, j_in;
   logic [LEN_W-1:0]            jhi_ff, jhi_in;
   logic signed [SAMPLE_W-1:0]  acc_ff, acc_in;
   logic                        rd_v_ff, rd_v_in;
   logic                        prod_v_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0]  out_result_ff, out_result_in;
   logic [POS_W-1:0]            out_pos_ff, out_pos_in;
   logic                        out_final_ff, out_final_in;
   logic                        done;

   logic [SUM_W-1:0]            n_x, l1_x, l2_x, j_x, i_x, jlo_x, jhi_x;
   logic                        out_free, pipe_empty;

   assign n_x  = SUM_W'(n_ff);
   assign l1_x = SUM_W'(first_len_ff);
   assign l2_x = SUM_W'(second_len_ff);
   assign j_x  = SUM_W'(j_ff);
   assign i_x  = n_x - j_x;

   // Term range of output n
   assign jlo_x = (n_x >= l2_x) ? n_x - l2_x + 1'b1 : '0;
   assign jhi_x = (n_x < l1_x) ? n_x : l1_x - 1'b1;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign pipe_empty = !rd_v_ff && !prod_v_ff;

   assign rd_first_addr  = {bank_ff, j_ff[IDX1_W-1:0]};
   assign rd_second_addr = {bank_ff, i_x[IDX2_W-1:0]};

   // Sequencer: one term per cycle, then drain and emit
   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      last_n_in     = last_n_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      jhi_in        = jhi_ff;
      acc_in        = prod_v_ff ? acc_ff + term_fn(prod_ff) : acc_ff;
      rd_v_in       = 1'b0;
      rd_en         = 1'b0;
      job_pop       = 1'b0;
      done          = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_result_in = out_result_ff;
      out_pos_in    = out_pos_ff;
      out_final_in  = out_final_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop       = 1'b1;
               bank_in       = job.bank;
               first_len_in  = job.first_len;
               second_len_in = job.second_len;
               last_n_in     = N_W'(SUM_W'(job.first_len) + SUM_W'(job.second_len) - 2'd2);
               n_in          = '0;
               state_in      = BK_START;
            end
         end
         BK_START: begin
            j_in     = LEN_W'(jlo_x);
            jhi_in   = LEN_W'(jhi_x);
            acc_in   = '0;
            state_in = BK_ISSUE;
         end
         BK_ISSUE: begin
            rd_en   = 1'b1;
            rd_v_in = 1'b1;
            if (j_ff == jhi_ff) begin
               state_in = BK_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            if (pipe_empty && out_free) begin
               out_valid_in  = 1'b1;
               out_result_in = acc_ff;
               out_pos_in    = POS_W'(n_ff);
               out_final_in  = (n_ff == last_n_ff);
               if (n_ff == last_n_ff) begin
                  done     = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = BK_START;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= rd_v_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath: job fields, counters, multiplier, accumulator and output register
   always_ff @(posedge clock) begin
      bank_ff       <= bank_in;
      first_len_ff  <= first_len_in;
      second_len_ff <= second_len_in;
      last_n_ff     <= last_n_in;
      n_ff          <= n_in;
      j_ff          <= j_in;
      jhi_ff        <= jhi_in;
      acc_ff        <= acc_in;
      prod_ff       <= $signed(rd_first_data) * $signed(rd_second_data);
      out_result_ff <= out_result_in;
      out_pos_ff    <= out_pos_in;
      out_final_ff  <= out_final_in;
   end

   assign stat.active = (state_ff != BK_IDLE);
   assign stat.done   = done;
   assign stat.bank   = bank_ff;

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = out_result_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_final_res = out_final_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fixed_point_linear_convolution.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// csr       in         csr_valid/csr_ready    csr_index, csr_data
// req       in         req_valid/req_ready    req_mode, req_sample
// rsp       out        rsp_valid/rsp_ready    rsp_result, rsp_position, rsp_final_res
//
// Samples load at one beat per cycle into one of two store banks; a full run
// queues a job and loading of the next run goes on in the other bank.
// One shared multiply-accumulate makes the outputs one after another.
// req_ready drops while both banks hold unfinished runs; rsp stalls hold the
// sequencer in its drain step. Reset needs no clearing pass.

module fixed_point_linear_convolution (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fplc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [fplc_pkg::CFG_W-1:0]          csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_mode,
   input  wire logic signed [fplc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [fplc_pkg::SAMPLE_W-1:0]     rsp_result,
   output logic [fplc_pkg::POS_W-1:0]               rsp_position,
   output logic                                     rsp_final_res
);

   import fplc_pkg::*;

   wr_type                    wr;
   logic                      job_push, job_pop, head_valid, queue_full;
   job_type                   push_job, head_job;
   back_stat_type             stat;
   logic                      rd_en;
   logic [FIRST_ADDR_W-1:0]   rd_first_addr;
   logic [SECOND_ADDR_W-1:0]  rd_second_addr;
   logic [SAMPLE_W-1:0]       rd_first_data, rd_second_data;

   // Front: config, loading, completion check
   fplc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_sample (req_sample),
      .wr         (wr),
      .job_push   (job_push),
      .job        (push_job),
      .queue_full (queue_full),
      .stat       (stat)
   );

   fplc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   // Sample stores, two banks each
   fplc_ram #(
      .WIDTH  (SAMPLE_W),
      .DEPTH  (2 ** FIRST_ADDR_W),
      .ADDR_W (FIRST_ADDR_W)
   ) u_first_store (
      .clock   (clock),
      .wr_en   (wr.first_en),
      .wr_addr (wr.first_addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_first_addr),
      .rd_data (rd_first_data)
   );

   fplc_ram #(
      .WIDTH  (SAMPLE_W),
      .DEPTH  (2 ** SECOND_ADDR_W),
      .ADDR_W (SECOND_ADDR_W)
   ) u_second_store (
      .clock   (clock),
      .wr_en   (wr.second_en),
      .wr_addr (wr.second_addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_second_addr),
      .rd_data (rd_second_data)
   );

   // Back: convolution sequencer and output register
   fplc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .job_pop        (job_pop),
      .rd_en          (rd_en),
      .rd_first_addr  (rd_first_addr),
      .rd_second_addr (rd_second_addr),
      .rd_first_data  (rd_first_data),
      .rd_second_data (rd_second_data),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result     (rsp_result),
      .rsp_position   (rsp_position),
      .rsp_final_res  (rsp_final_res)
   );

   // A finished job never overruns the queue
   assert property (@(posedge clock) disable iff (reset) job_push |-> !queue_full)
      else $error("job pushed into a full queue");

   // Loading never writes the bank that the back part is reading
   assert property (@(posedge clock) disable iff (reset)
      (wr.first_en && stat.active) |-> (wr.first_addr[FIRST_ADDR_W-1] != stat.bank))
      else $error("first store write hit the bank under computation");

   assert property (@(posedge clock) disable iff (reset)
      (wr.second_en && stat.active) |-> (wr.second_addr[SECOND_ADDR_W-1] != stat.bank))
      else $error("second store write hit the bank under computation");

   // Releasing a bank coincides with presenting the last output of its run
   assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (rsp_valid && rsp_final_res))
      else $error("bank released without a final output");

endmodule

`default_nettype wire
